// ===== src/xrng_pkg.sv =====
`default_nettype none
package xrng_pkg;

   localparam int WORD_W = 32;

   typedef logic [WORD_W-1:0] word_type;

   // SplitMix32 constants
   localparam word_type SM_GOLDEN = 32'h9e37_79b9;
   localparam word_type SM_MUL_A  = 32'h85eb_ca6b;
   localparam word_type SM_MUL_B  = 32'hc2b2_ae35;

   // xoshiro128** shift and rotate amounts
   localparam int XS_SHL   = 9;
   localparam int XS_ROT   = 11;
   localparam int SS_ROT   = 7;

   // request kinds
   localparam logic REQ_RAW     = 1'b0;
   localparam logic REQ_BOUNDED = 1'b1;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   function automatic word_type rotl(input word_type v, input int n);
      rotl = (v << n) | (v >> (WORD_W - n));
   endfunction

endpackage
`default_nettype wire

// ===== src/xrng_ifs.sv =====
`default_nettype none
interface xrng_req_if;
   import xrng_pkg::*;
   logic     valid;
   logic     ready;
   logic     req_type;
   word_type bound;
   modport source (output valid, output req_type, output bound, input ready);
   modport sink   (input valid, input req_type, input bound, output ready);
endinterface

interface xrng_rsp_if;
   import xrng_pkg::*;
   logic     valid;
   logic     ready;
   word_type value;
   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface xrng_csr_if;
   import xrng_pkg::*;
   logic     valid;
   logic     ready;
   word_type seed;
   modport source (output valid, output seed, input ready);
   modport sink   (input valid, input seed, output ready);
endinterface
`default_nettype wire

// ===== src/xrng_div.sv =====
`default_nettype none
module xrng_div
   import xrng_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   input  wire word_type dividend,
   input  wire word_type divisor,
   output div_stat_type stat,
   output word_type     remainder
);

   logic [4:0] cnt_ff, cnt_in;
   logic       busy_ff, busy_in;
   logic       done_ff, done_in;
   word_type   dvd_ff, dvd_in;
   word_type   dsr_ff, dsr_in;
   word_type   rem_ff, rem_in;

   logic [WORD_W:0] shifted;
   logic            ge;

   // restoring division, one quotient bit per cycle
   always_comb begin
      shifted = {rem_ff, dvd_ff[WORD_W-1]};
      ge      = shifted >= {1'b0, dsr_ff};
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      if (start) begin
         dvd_in  = dividend;
         dsr_in  = divisor;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[WORD_W-2:0], 1'b0};
         rem_in = ge ? WORD_W'(shifted - {1'b0, dsr_ff}) : shifted[WORD_W-1:0];
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign remainder = rem_ff;

`ifndef SYNTHESIS
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("remainder ready without a running division");
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> rem_ff < dsr_ff)
      else $error("remainder not below divisor");
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("division started while busy");
`endif

endmodule
`default_nettype wire

// ===== src/xoshiro128ss_bounded_rng.sv =====
`default_nettype none
// channel   modport  handshake     payload
// req_chan  sink     valid/ready   req_type (1), bound (32)
// rsp_chan  source   valid/ready   value (32)
// csr_chan  sink     valid/ready   seed (32)
//
// Raw draw: the scrambled word is registered, then passed on to the output register.
// Bounded draw: rejection draws, then the shared divider's remainder, plus a threshold
// division first when bound differs from the last bound whose threshold was computed.
// Reset and every seed write run a SplitMix32 expansion, not ready meanwhile.
// A new request is taken while a finished result waits in the output register.
module xoshiro128ss_bounded_rng
   import xrng_pkg::*;
(
   input wire logic  clock,
   input wire logic  reset,
   xrng_req_if.sink  req_chan,
   xrng_rsp_if.source rsp_chan,
   xrng_csr_if.sink  csr_chan
);

   typedef enum logic [2:0] {
      ST_SEED_A,
      ST_SEED_B,
      ST_SEED_C,
      ST_IDLE,
      ST_THRESH,
      ST_DRAW,
      ST_MOD,
      ST_OUT
   } state_type;

   state_type  state_ff, state_in;
   word_type   gen_ff [4];
   word_type   gen_in [4];
   word_type   acc_ff, acc_in;
   word_type   mul_ff, mul_in;
   logic [1:0] widx_ff, widx_in;
   word_type   lim_ff, lim_in;
   word_type   floor_ff, floor_in;
   word_type   clim_ff, clim_in;
   logic       cvld_ff, cvld_in;
   word_type   res_ff, res_in;
   logic       rsp_vld_ff, rsp_vld_in;
   word_type   rsp_val_ff, rsp_val_in;

   word_type     mul_a, mul_b, z, fin;
   word_type     d_mul5, d_rot, d_out;
   word_type     t2, t3;
   logic         do_draw;
   logic         req_go, csr_go;
   logic         div_go;
   word_type     div_dvd, div_dsr, div_rem;
   div_stat_type div_st;

   xrng_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_go),
      .dividend  (div_dvd),
      .divisor   (div_dsr),
      .stat      (div_st),
      .remainder (div_rem)
   );

   assign csr_chan.ready = state_ff == ST_IDLE;
   assign req_chan.ready = state_ff == ST_IDLE && !csr_chan.valid;
   assign csr_go = csr_chan.valid && csr_chan.ready;
   assign req_go = req_chan.valid && req_chan.ready;

   // starstar scrambler on word 1
   assign d_mul5 = gen_ff[1] + (gen_ff[1] << 2);
   assign d_rot  = rotl(d_mul5, SS_ROT);
   assign d_out  = d_rot + (d_rot << 3);
   assign t2     = gen_ff[2] ^ gen_ff[0];
   assign t3     = gen_ff[3] ^ gen_ff[1];

   // shared 32x32 multiplier of the seed expansion
   assign mul_b = (state_ff == ST_SEED_A) ? SM_MUL_A : SM_MUL_B;
   assign fin   = mul_ff ^ (mul_ff >> 16);

   always_comb begin
      state_in   = state_ff;
      gen_in     = gen_ff;
      acc_in     = acc_ff;
      widx_in    = widx_ff;
      lim_in     = lim_ff;
      floor_in   = floor_ff;
      clim_in    = clim_ff;
      cvld_in    = cvld_ff;
      res_in     = res_ff;
      rsp_vld_in = rsp_vld_ff && !rsp_chan.ready;
      rsp_val_in = rsp_val_ff;
      do_draw    = 1'b0;
      div_go     = 1'b0;
      div_dvd    = d_out;
      div_dsr    = lim_ff;
      z          = acc_ff;
      mul_a      = acc_ff;

      case (state_ff)
         ST_SEED_A: begin
            acc_in   = acc_ff + SM_GOLDEN;
            z        = acc_in ^ (acc_in >> 16);
            mul_a    = z;
            state_in = ST_SEED_B;
         end
         ST_SEED_B: begin
            z        = mul_ff ^ (mul_ff >> 13);
            mul_a    = z;
            state_in = ST_SEED_C;
         end
         ST_SEED_C: begin
            gen_in[widx_ff] = fin;
            widx_in         = widx_ff + 2'd1;
            state_in        = ST_SEED_A;
            if (widx_ff == 2'd3) begin
               state_in = ST_IDLE;
               // an all-zero state would lock up; force word 0 to one
               if ((gen_ff[0] | gen_ff[1] | gen_ff[2] | fin) == '0) begin
                  gen_in[0] = word_type'(1);
               end
            end
         end
         ST_IDLE: begin
            if (csr_go) begin
               acc_in   = csr_chan.seed;
               widx_in  = '0;
               state_in = ST_SEED_A;
            end else if (req_go) begin
               lim_in = req_chan.bound;
               if (req_chan.req_type == REQ_RAW) begin
                  do_draw  = 1'b1;
                  res_in   = d_out;
                  state_in = ST_OUT;
               end else if (req_chan.bound < word_type'(2)) begin
                  res_in   = '0;
                  state_in = ST_OUT;
               end else if (cvld_ff && clim_ff == req_chan.bound) begin
                  state_in = ST_DRAW;
               end else begin
                  div_go   = 1'b1;
                  div_dvd  = word_type'(0) - req_chan.bound;
                  div_dsr  = req_chan.bound;
                  cvld_in  = 1'b0;
                  state_in = ST_THRESH;
               end
            end
         end
         ST_THRESH: begin
            if (div_st.done) begin
               floor_in = div_rem;
               clim_in  = lim_ff;
               cvld_in  = 1'b1;
               state_in = ST_DRAW;
            end
         end
         ST_DRAW: begin
            do_draw = 1'b1;
            // reject draws below the threshold, draw again
            if (d_out >= floor_ff) begin
               div_go   = 1'b1;
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            if (div_st.done) begin
               res_in   = div_rem;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_vld_ff || rsp_chan.ready) begin
               rsp_vld_in = 1'b1;
               rsp_val_in = res_ff;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (do_draw) begin
         gen_in[0] = gen_ff[0] ^ t3;
         gen_in[1] = gen_ff[1] ^ t2;
         gen_in[2] = t2 ^ (gen_ff[1] << XS_SHL);
         gen_in[3] = rotl(t3, XS_ROT);
      end
   end

   assign mul_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_SEED_A;
         acc_ff     <= '0;
         widx_ff    <= '0;
         cvld_ff    <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         acc_ff     <= acc_in;
         widx_ff    <= widx_in;
         cvld_ff    <= cvld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      gen_ff     <= gen_in;
      mul_ff     <= mul_in;
      lim_ff     <= lim_in;
      floor_ff   <= floor_in;
      clim_ff    <= clim_in;
      res_ff     <= res_in;
      rsp_val_ff <= rsp_val_in;
   end

   assign rsp_chan.valid = rsp_vld_ff;
   assign rsp_chan.value = rsp_val_ff;

`ifndef SYNTHESIS
   a_state_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> (gen_ff[0] | gen_ff[1] | gen_ff[2] | gen_ff[3]) != '0)
      else $error("generator state is all zero");
   a_floor_below_bound: assert property (@(posedge clock) disable iff (reset)
      cvld_ff |-> floor_ff < clim_ff)
      else $error("cached threshold not below its bound");
   a_div_idle_on_start: assert property (@(posedge clock) disable iff (reset)
      div_go |-> !div_st.busy)
      else $error("divider started while busy");
   a_wait_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MOD || state_ff == ST_THRESH) |-> div_st.busy || div_st.done)
      else $error("waiting on a divider that is not running");
`endif

endmodule
`default_nettype wire
